// ===== rtl/assert_macros.svh =====
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/cia_pkg.sv =====
package cia_pkg;

    localparam int KindW = 2;
    localparam int AddrW = 4;
    localparam int ByteW = 8;
    localparam int TimerW = 16;
    localparam int TodW = 32;

    localparam logic [KindW-1:0] KIND_READ = 2'd0;
    localparam logic [KindW-1:0] KIND_WRITE = 2'd1;
    localparam logic [KindW-1:0] KIND_TICK = 2'd2;

    localparam logic [AddrW-1:0] REG_PRA = 4'd0;
    localparam logic [AddrW-1:0] REG_PRB = 4'd1;
    localparam logic [AddrW-1:0] REG_DDRA = 4'd2;
    localparam logic [AddrW-1:0] REG_DDRB = 4'd3;
    localparam logic [AddrW-1:0] REG_TALO = 4'd4;
    localparam logic [AddrW-1:0] REG_TAHI = 4'd5;
    localparam logic [AddrW-1:0] REG_TBLO = 4'd6;
    localparam logic [AddrW-1:0] REG_TBHI = 4'd7;
    localparam logic [AddrW-1:0] REG_TOD10 = 4'd8;
    localparam logic [AddrW-1:0] REG_TODS = 4'd9;
    localparam logic [AddrW-1:0] REG_TODM = 4'd10;
    localparam logic [AddrW-1:0] REG_TODH = 4'd11;
    localparam logic [AddrW-1:0] REG_ICR = 4'd13;
    localparam logic [AddrW-1:0] REG_CRA = 4'd14;
    localparam logic [AddrW-1:0] REG_CRB = 4'd15;

    localparam logic [TimerW-1:0] TIMER_RESET = 16'hffff;
    localparam logic [TimerW-1:0] CYCLES_RESET = 16'd1;

    typedef struct packed {
        logic [ByteW-1:0] write_data;
        logic [AddrW-1:0] address;
        logic [KindW-1:0] kind;
        logic tenth_tick;
    } item_t;

    typedef struct packed {
        logic [ByteW-1:0] read_data;
        logic irq_line;
        logic [ByteW-1:0] port_b_latch;
    } result_t;

    function automatic logic [ByteW-1:0] bcd_step(input logic [ByteW-1:0] v,
                                                  input logic [ByteW-1:0] hi_mask);
        logic [4:0] lo;
        logic [ByteW-1:0] hi;
        lo = {1'b0, v[3:0]} + 5'd1;
        hi = v & hi_mask;
        if (lo > 5'd9) begin
            hi = hi + 8'h10;
            lo = 5'd0;
        end
        return hi | {4'd0, lo[3:0]};
    endfunction

    function automatic logic [TodW-1:0] tod_next(input logic [TodW-1:0] c);
        logic [ByteW-1:0] t, s, m, h, pm;
        t = c[7:0] + 8'd1;
        s = c[15:8];
        m = c[23:16];
        h = c[31:24];
        if (t > 8'd9) begin
            t = 8'd0;
            s = bcd_step(s, 8'hf0);
            if (s >= 8'h60) begin
                s = 8'd0;
                m = bcd_step(m, 8'hf0);
                if (m >= 8'h60) begin
                    pm = h & 8'h80;
                    m = 8'd0;
                    h = bcd_step(h, 8'h70);
                    if (h > 8'h12) begin
                        pm = pm ^ 8'h80;
                        h = 8'h01;
                    end
                    h = h | pm;
                end
            end
        end
        return {h, m, s, t};
    endfunction

endpackage

// ===== rtl/cia_in_stage.sv =====
module cia_in_stage (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    input  cia_pkg::item_t s_item,
    output logic s_ready,
    output logic q_valid,
    output cia_pkg::item_t q_item,
    input  logic q_ready
);
    import cia_pkg::*;

    logic valid_reg;
    item_t item_reg;

    assign s_ready = !valid_reg || q_ready;
    assign q_valid = valid_reg;
    assign q_item = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= s_item;
        end
    end
endmodule

// ===== rtl/cia_core.sv =====
`include "assert_macros.svh"
module cia_core (
    input  logic aclk,
    input  logic aresetn,
    input  logic cfg_we,
    input  logic [cia_pkg::TimerW-1:0] cfg_wdata,
    input  logic q_valid,
    input  cia_pkg::item_t q_item,
    output logic q_ready,
    output logic m_valid,
    output cia_pkg::result_t m_res,
    input  logic m_ready
);
    import cia_pkg::*;

    logic [ByteW-1:0] rf_reg [16];
    logic [ByteW-1:0] rf_next [16];
    logic [TimerW-1:0] ta_reg, ta_next, tar_reg, tar_next;
    logic [TimerW-1:0] tb_reg, tb_next, tbr_reg, tbr_next;
    logic [4:0] mask_reg, mask_next;
    logic bcyc_reg, bcyc_next, bau_reg, bau_next;
    logic [TodW-1:0] tod_reg, tod_next_v, alarm_reg, alarm_next;
    logic run_reg, run_next, hold_reg, hold_next, irq_reg, irq_next;
    logic [TimerW-1:0] cyc_reg;
    logic out_valid_reg;
    result_t res_reg, res_next;
    logic fire;
    logic [ByteW-1:0] d, rd, cra, crb;
    logic [AddrW-1:0] a;
    logic b_uf, b_uf2;
    logic [TodW-1:0] tadv;

    assign q_ready = !out_valid_reg || m_ready;
    assign fire = q_valid && q_ready;
    assign m_valid = out_valid_reg;
    assign m_res = res_reg;

    always_comb begin
        for (int i = 0; i < 16; i++) rf_next[i] = rf_reg[i];
        ta_next = ta_reg; tar_next = tar_reg; tb_next = tb_reg; tbr_next = tbr_reg;
        mask_next = mask_reg; bcyc_next = bcyc_reg; bau_next = bau_reg;
        tod_next_v = tod_reg; alarm_next = alarm_reg; run_next = run_reg;
        hold_next = hold_reg; irq_next = irq_reg;
        a = q_item.address;
        d = q_item.write_data;
        rd = '0;
        b_uf = 1'b0;
        b_uf2 = 1'b0;
        cra = rf_reg[REG_CRA];
        crb = rf_reg[REG_CRB];
        tadv = tod_next(tod_reg);
        if (q_item.kind == KIND_READ) begin
            unique case (a)
                REG_PRA: rd = (rf_reg[REG_PRA] | ~rf_reg[REG_DDRA]) & 8'h3f;
                REG_PRB: rd = rf_reg[REG_PRB] | ~rf_reg[REG_DDRB];
                REG_TALO: rd = ta_reg[7:0];
                REG_TAHI: rd = ta_reg[15:8];
                REG_TBLO: rd = tb_reg[7:0];
                REG_TBHI: rd = tb_reg[15:8];
                REG_TOD10: begin rd = tod_reg[7:0]; hold_next = 1'b0; end
                REG_TODS: rd = tod_reg[15:8];
                REG_TODM: rd = tod_reg[23:16];
                REG_TODH: begin rd = tod_reg[31:24]; hold_next = 1'b1; end
                REG_ICR: begin
                    rd = rf_reg[REG_ICR] & 8'h9f;
                    rf_next[REG_ICR] = '0;
                    irq_next = 1'b0;
                end
                default: rd = rf_reg[a];
            endcase
        end else if (q_item.kind == KIND_WRITE) begin
            unique case (a)
                REG_TAHI: begin
                    rf_next[a] = d;
                    tar_next = {d, rf_reg[REG_TALO]};
                    if (!cra[0]) ta_next = {d, rf_reg[REG_TALO]};
                end
                REG_TBHI: begin
                    rf_next[a] = d;
                    tbr_next = {d, rf_reg[REG_TBLO]};
                    if (!crb[0]) tb_next = {d, rf_reg[REG_TBLO]};
                end
                REG_TOD10, REG_TODS, REG_TODM, REG_TODH: begin
                    priority if (a == REG_TOD10) begin
                        d = d & 8'h0f; run_next = 1'b1;
                    end else if (a == REG_TODH) begin
                        d = d & 8'h1f; run_next = 1'b0;
                    end else begin
                        d = d & 8'h3f;
                    end
                    rf_next[a] = d;
                    if (crb[7]) alarm_next[a[1:0]*8 +: 8] = d;
                    else tod_next_v[a[1:0]*8 +: 8] = d;
                end
                REG_ICR: begin
                    rf_next[REG_ICR] = '0;
                    irq_next = 1'b0;
                    if (d[7]) mask_next = mask_reg | d[4:0];
                    else mask_next = mask_reg & ~d[4:0];
                end
                REG_CRA: begin
                    if (d[4]) begin
                        d[4] = 1'b0;
                        tar_next = {rf_reg[REG_TAHI], rf_reg[REG_TALO]};
                        ta_next = tar_next;
                    end
                    rf_next[a] = d;
                end
                REG_CRB: begin
                    if (d[4]) begin
                        d[4] = 1'b0;
                        tbr_next = {rf_reg[REG_TBHI], rf_reg[REG_TBLO]};
                        tb_next = tbr_next;
                    end
                    rf_next[a] = d;
                    if (d[6:5] == 2'b00) bcyc_next = 1'b1;
                    else if (!d[6]) bau_next = 1'b1;
                end
                default: rf_next[a] = d;
            endcase
        end else if (q_item.kind == KIND_TICK) begin
            if (cra[0]) begin
                if (cyc_reg > ta_reg) begin
                    if (cra[1]) begin
                        rf_next[REG_DDRB][6] = 1'b0;
                        rf_next[REG_PRB][6] = cra[2] ? ~rf_reg[REG_PRB][6] : 1'b1;
                    end
                    ta_next = tar_reg;
                    if (cra[3]) rf_next[REG_CRA][0] = 1'b0;
                    rf_next[REG_ICR][0] = 1'b1;
                    if (mask_reg[0]) begin rf_next[REG_ICR][7] = 1'b1; irq_next = 1'b1; end
                    if (bau_reg) begin
                        if (tb_reg == '0) b_uf = 1'b1;
                        else tb_next = tb_reg - 16'd1;
                    end
                end else begin
                    ta_next = ta_reg - cyc_reg;
                end
            end
            // underflow from a timer A underflow, before the cycle count
            if (b_uf) begin
                tb_next = tbr_reg;
                if (crb[3]) begin
                    rf_next[REG_CRB][0] = 1'b0;
                    bcyc_next = 1'b0;
                    bau_next = 1'b0;
                end
                rf_next[REG_ICR][1] = 1'b1;
                if (mask_reg[1]) begin rf_next[REG_ICR][7] = 1'b1; irq_next = 1'b1; end
                if (crb[1]) begin
                    rf_next[REG_DDRB][7] = 1'b0;
                    rf_next[REG_PRB][7] = crb[2] ? ~rf_next[REG_PRB][7] : 1'b1;
                end
            end
            if (bcyc_next) begin
                if (cyc_reg > tb_next) b_uf2 = 1'b1;
                else tb_next = tb_next - cyc_reg;
            end
            if (b_uf2) begin
                tb_next = tbr_reg;
                if (crb[3]) begin
                    rf_next[REG_CRB][0] = 1'b0;
                    bcyc_next = 1'b0;
                    bau_next = 1'b0;
                end
                rf_next[REG_ICR][1] = 1'b1;
                if (mask_reg[1]) begin rf_next[REG_ICR][7] = 1'b1; irq_next = 1'b1; end
                if (crb[1]) begin
                    rf_next[REG_DDRB][7] = 1'b0;
                    rf_next[REG_PRB][7] = crb[2] ? ~rf_next[REG_PRB][7] : 1'b1;
                end
            end
            if (run_reg && q_item.tenth_tick) begin
                tod_next_v = tadv;
                if (tadv >= alarm_reg) begin
                    rf_next[REG_ICR][2] = 1'b1;
                    if (mask_reg[2]) begin rf_next[REG_ICR][7] = 1'b1; irq_next = 1'b1; end
                end
            end
        end
        res_next.read_data = rd;
        res_next.irq_line = irq_next;
        res_next.port_b_latch = rf_next[REG_PRB];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 16; i++) rf_reg[i] <= '0;
            ta_reg <= TIMER_RESET; tar_reg <= TIMER_RESET;
            tb_reg <= TIMER_RESET; tbr_reg <= TIMER_RESET;
            mask_reg <= '0; bcyc_reg <= 1'b0; bau_reg <= 1'b0;
            tod_reg <= '0; alarm_reg <= '0; run_reg <= 1'b0;
            hold_reg <= 1'b0; irq_reg <= 1'b0;
            cyc_reg <= CYCLES_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) cyc_reg <= cfg_wdata;
            if (q_ready) out_valid_reg <= q_valid;
            if (fire) begin
                for (int i = 0; i < 16; i++) rf_reg[i] <= rf_next[i];
                ta_reg <= ta_next; tar_reg <= tar_next;
                tb_reg <= tb_next; tbr_reg <= tbr_next;
                mask_reg <= mask_next; bcyc_reg <= bcyc_next; bau_reg <= bau_next;
                tod_reg <= tod_next_v; alarm_reg <= alarm_next; run_reg <= run_next;
                hold_reg <= hold_next; irq_reg <= irq_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) res_reg <= res_next;
    end

    `ASSERT_NEXT(a_irq_out, aclk, aresetn, fire, m_res.irq_line == irq_reg)
    `ASSERT_NEXT(a_pb_out, aclk, aresetn, fire, m_res.port_b_latch == rf_reg[REG_PRB])
    `ASSERT_IMPL(a_irq_icr, aclk, aresetn, irq_reg, rf_reg[REG_ICR][7])
endmodule

// ===== rtl/cia_timer_tod_interrupt.sv =====
// Interface adapter with two 16-bit timers, a 12-hour BCD time-of-day clock
// with alarm and an interrupt control register. One item (bus read, bus write
// or tick) is taken per cycle unless the receiver stalls; its input is
// registered, then one registered pass makes the result and the whole state update.
`include "assert_macros.svh"
module cia_timer_tod_interrupt (
    input  logic aclk,
    input  logic aresetn,
    input  logic cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic s_tvalid,
    output logic s_tready,
    // address, write_data
    input  logic [15:0] s_tdata,
    // kind, tenth_tick
    input  logic [2:0] s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // read_data, irq_line, port_b_latch
    output logic [23:0] m_tdata
);
    import cia_pkg::*;

    item_t s_item, q_item;
    result_t res;
    logic q_valid, q_ready;

    assign s_item.address = s_tdata[3:0];
    assign s_item.write_data = s_tdata[11:4];
    assign s_item.kind = s_tuser[1:0];
    assign s_item.tenth_tick = s_tuser[2];

    cia_in_stage u_in (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_tvalid), .s_item(s_item), .s_ready(s_tready),
        .q_valid(q_valid), .q_item(q_item), .q_ready(q_ready)
    );

    cia_core u_core (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .q_valid(q_valid), .q_item(q_item), .q_ready(q_ready),
        .m_valid(m_tvalid), .m_res(res), .m_ready(m_tready)
    );

    assign m_tdata = {7'd0, res.port_b_latch, res.irq_line, res.read_data};

    `ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata))
endmodule

// ===== tb/cia_timer_tod_interrupt_tb.sv =====
`timescale 1ns / 1ps

module cia_timer_tod_interrupt_tb;
    import cia_pkg::*;

    localparam logic [KindW-1:0] KIND_SPARE = 2'd3;
    localparam logic [AddrW-1:0] REG_SDR = 4'd12;
    localparam int IdleLimit = 5000;
    localparam int HoldCycles = 300;

    typedef struct {
        logic [KindW-1:0] kind;
        logic [AddrW-1:0] addr;
        logic [ByteW-1:0] data;
        logic tenth;
        bit typed;
        logic [ByteW-1:0] rd;
    } row_t;

    typedef struct packed {
        logic [ByteW-1:0] rd;
        logic irq;
        logic [ByteW-1:0] pb;
    } outcome_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [15:0] s_tdata = '0;
    logic [2:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [23:0] m_tdata;

    cia_timer_tod_interrupt dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // adapter state mirror
    logic [7:0] regs [16];
    logic [15:0] ta_cnt, ta_rel, tb_cnt, tb_rel, tick_cycles;
    logic [4:0] irq_mask;
    logic b_on_cycles, b_on_a;
    logic [31:0] tod_now, tod_alarm;
    logic tod_run, tod_hold, irq_now;

    outcome_t pending_results[$];
    int errors = 0;
    int sent = 0;
    int received = 0;
    int underflows = 0;
    int idle_cycles = 0;
    int stall_mode = 0;
    bit hold_req = 0;

    function automatic void raise_src(input logic [7:0] bit_sel);
        regs[REG_ICR] = regs[REG_ICR] | bit_sel;
        if ((irq_mask & bit_sel[4:0]) != 0) begin
            regs[REG_ICR] = regs[REG_ICR] | 8'h80;
            irq_now = 1'b1;
        end
    endfunction

    function automatic void b_expire();
        logic [7:0] crb;
        crb = regs[REG_CRB];
        tb_cnt = tb_rel;
        underflows++;
        if (crb[3]) begin
            regs[REG_CRB] = crb & 8'hfe;
            b_on_cycles = 1'b0;
            b_on_a = 1'b0;
        end
        raise_src(8'h02);
        if (crb[1]) begin
            regs[REG_DDRB] = regs[REG_DDRB] & 8'h7f;
            if (crb[2]) regs[REG_PRB] = regs[REG_PRB] ^ 8'h80;
            else regs[REG_PRB] = regs[REG_PRB] | 8'h80;
        end
    endfunction

    function automatic logic [7:0] digit_inc(input logic [7:0] v, input logic [7:0] hm);
        logic [4:0] lo;
        logic [7:0] hi;
        lo = {1'b0, v[3:0]} + 5'd1;
        hi = v & hm;
        if (lo > 5'd9) begin
            hi = hi + 8'h10;
            lo = 5'd0;
        end
        return hi | {3'd0, lo};
    endfunction

    function automatic void tod_tick();
        logic [7:0] t, s, m, h, pm;
        t = tod_now[7:0] + 8'd1;
        s = tod_now[15:8];
        m = tod_now[23:16];
        h = tod_now[31:24];
        if (t > 8'd9) begin
            t = 8'd0;
            s = digit_inc(s, 8'hf0);
            if (s >= 8'h60) begin
                s = 8'd0;
                m = digit_inc(m, 8'hf0);
                if (m >= 8'h60) begin
                    pm = h & 8'h80;
                    m = 8'd0;
                    h = digit_inc(h, 8'h70);
                    if (h > 8'h12) begin
                        pm = pm ^ 8'h80;
                        h = 8'h01;
                    end
                    h = h | pm;
                end
            end
        end
        tod_now = {h, m, s, t};
        if (tod_now >= tod_alarm) raise_src(8'h04);
    endfunction

    function automatic void tod_store(input int sh, input logic [7:0] v);
        if (regs[REG_CRB][7]) tod_alarm = (tod_alarm & ~(32'hff << sh)) | (32'(v) << sh);
        else tod_now = (tod_now & ~(32'hff << sh)) | (32'(v) << sh);
    endfunction

    function automatic logic [7:0] bus_rd(input logic [3:0] a);
        logic [7:0] v;
        case (a)
            REG_PRA: return (regs[REG_PRA] | ~regs[REG_DDRA]) & 8'h3f;
            REG_PRB: return regs[REG_PRB] | ~regs[REG_DDRB];
            REG_TALO: return ta_cnt[7:0];
            REG_TAHI: return ta_cnt[15:8];
            REG_TBLO: return tb_cnt[7:0];
            REG_TBHI: return tb_cnt[15:8];
            REG_TOD10: begin
                tod_hold = 1'b0;
                return tod_now[7:0];
            end
            REG_TODS: return tod_now[15:8];
            REG_TODM: return tod_now[23:16];
            REG_TODH: begin
                tod_hold = 1'b1;
                return tod_now[31:24];
            end
            REG_ICR: begin
                v = regs[REG_ICR];
                regs[REG_ICR] = 8'h00;
                irq_now = 1'b0;
                return v & 8'h9f;
            end
            default: return regs[a];
        endcase
    endfunction

    function automatic void bus_wr(input logic [3:0] a, input logic [7:0] din);
        logic [7:0] d;
        d = din;
        case (a)
            REG_TAHI: begin
                regs[REG_TAHI] = d;
                ta_rel = {d, regs[REG_TALO]};
                if (!regs[REG_CRA][0]) ta_cnt = ta_rel;
            end
            REG_TBHI: begin
                regs[REG_TBHI] = d;
                tb_rel = {d, regs[REG_TBLO]};
                if (!regs[REG_CRB][0]) tb_cnt = tb_rel;
            end
            REG_TOD10: begin
                d = d & 8'h0f;
                tod_run = 1'b1;
                regs[a] = d;
                tod_store(0, d);
            end
            REG_TODS, REG_TODM: begin
                d = d & 8'h3f;
                regs[a] = d;
                tod_store((int'(a) - 8) * 8, d);
            end
            REG_TODH: begin
                d = d & 8'h1f;
                tod_run = 1'b0;
                regs[a] = d;
                tod_store(24, d);
            end
            REG_ICR: begin
                regs[REG_ICR] = 8'h00;
                irq_now = 1'b0;
                if (d[7]) irq_mask = irq_mask | d[4:0];
                else irq_mask = irq_mask & ~d[4:0];
            end
            REG_CRA: begin
                if (d[4]) begin
                    d = d & 8'hef;
                    ta_rel = {regs[REG_TAHI], regs[REG_TALO]};
                    ta_cnt = ta_rel;
                end
                regs[REG_CRA] = d;
            end
            REG_CRB: begin
                if (d[4]) begin
                    d = d & 8'hef;
                    tb_rel = {regs[REG_TBHI], regs[REG_TBLO]};
                    tb_cnt = tb_rel;
                end
                regs[REG_CRB] = d;
                if (d[6:5] == 2'b00) b_on_cycles = 1'b1;
                else if (!d[6]) b_on_a = 1'b1;
            end
            default: regs[a] = d;
        endcase
    endfunction

    function automatic void time_tick(input logic tenth);
        logic [7:0] cra;
        cra = regs[REG_CRA];
        if (cra[0]) begin
            if (tick_cycles > ta_cnt) begin
                underflows++;
                if (cra[1]) begin
                    regs[REG_DDRB] = regs[REG_DDRB] & 8'hbf;
                    if (cra[2]) regs[REG_PRB] = regs[REG_PRB] ^ 8'h40;
                    else regs[REG_PRB] = regs[REG_PRB] | 8'h40;
                end
                ta_cnt = ta_rel;
                if (cra[3]) regs[REG_CRA] = cra & 8'hfe;
                raise_src(8'h01);
                if (b_on_a) begin
                    if (tb_cnt == 16'd0) b_expire();
                    else tb_cnt = tb_cnt - 16'd1;
                end
            end else begin
                ta_cnt = ta_cnt - tick_cycles;
            end
        end
        if (b_on_cycles) begin
            if (tick_cycles > tb_cnt) b_expire();
            else tb_cnt = tb_cnt - tick_cycles;
        end
        if (tod_run && tenth) tod_tick();
    endfunction

    function automatic outcome_t adapter_step(input row_t r);
        outcome_t o;
        o.rd = 8'h00;
        if (r.kind == KIND_READ) o.rd = bus_rd(r.addr);
        else if (r.kind == KIND_WRITE) bus_wr(r.addr, r.data);
        else if (r.kind == KIND_TICK) time_tick(r.tenth);
        o.irq = irq_now;
        o.pb = regs[REG_PRB];
        return o;
    endfunction

    task automatic send(input row_t r);
        outcome_t o;
        s_tvalid <= 1'b1;
        s_tdata <= {4'd0, r.data, r.addr};
        s_tuser <= {r.tenth, r.kind};
        do @(posedge aclk); while (!s_tready);
        o = adapter_step(r);
        if (r.typed && o.rd !== r.rd) begin
            $display("%0t: table read of reg %0d expected %h, predicted %h",
                     $time, r.addr, r.rd, o.rd);
            errors++;
        end
        pending_results.push_back(o);
        sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_cycles(input logic [15:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        tick_cycles = v;
    endtask

    function automatic row_t rnd_row();
        row_t r;
        int p;
        p = $urandom_range(0, 99);
        r.kind = p < 40 ? KIND_TICK : p < 70 ? KIND_WRITE : p < 97 ? KIND_READ : KIND_SPARE;
        r.addr = 4'($urandom_range(0, 15));
        r.data = 8'($urandom_range(0, 255));
        r.tenth = 1'($urandom_range(0, 1));
        r.typed = 0;
        r.rd = 0;
        if (r.kind == KIND_WRITE) begin
            if ((r.addr == REG_TAHI || r.addr == REG_TBHI) && $urandom_range(0, 9) < 8)
                r.data = 8'h00;
            if ((r.addr == REG_TALO || r.addr == REG_TBLO) && $urandom_range(0, 9) < 7)
                r.data = 8'($urandom_range(0, 40));
        end
        return r;
    endfunction

    function automatic row_t mk(input logic [1:0] k, input logic [3:0] a, input logic [7:0] d,
                                input logic t, input bit ty = 0, input logic [7:0] rd = 0);
        row_t r;
        r.kind = k;
        r.addr = a;
        r.data = d;
        r.tenth = t;
        r.typed = ty;
        r.rd = rd;
        return r;
    endfunction

    // receiver stall patterns
    always begin
        int n;
        @(posedge aclk);
        if (hold_req) begin
            m_tready <= 1'b0;
            for (n = 0; n < HoldCycles; n++) @(posedge aclk);
            hold_req = 0;
        end else begin
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= (($time / 12) % 5 != 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        outcome_t got, want;
        if (aresetn) begin
            idle_cycles++;
            if (s_tvalid && s_tready) idle_cycles = 0;
            if (m_tvalid && m_tready) begin
                idle_cycles = 0;
                got.rd = m_tdata[7:0];
                got.irq = m_tdata[8];
                got.pb = m_tdata[16:9];
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    received++;
                    if (got.rd !== want.rd)
                        $display("%0t: read_data expected %h actual %h", $time, want.rd, got.rd);
                    if (got.irq !== want.irq)
                        $display("%0t: irq_line expected %b actual %b", $time, want.irq, got.irq);
                    if (got.pb !== want.pb)
                        $display("%0t: port_b_latch expected %h actual %h",
                                 $time, want.pb, got.pb);
                    if (got !== want) errors++;
                end
            end
            if (idle_cycles >= IdleLimit) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    row_t directed[$];
    logic [15:0] cycle_set[6] = '{16'd1, 16'd0, 16'hffff, 16'd3, 16'd1, 16'd9};

    initial begin
        int i, ph, gap, burst;
        for (i = 0; i < 16; i++) regs[i] = 8'h00;
        ta_cnt = TIMER_RESET; ta_rel = TIMER_RESET;
        tb_cnt = TIMER_RESET; tb_rel = TIMER_RESET;
        irq_mask = '0; b_on_cycles = 0; b_on_a = 0;
        tod_now = '0; tod_alarm = '0; tod_run = 0; tod_hold = 0; irq_now = 0;
        tick_cycles = CYCLES_RESET;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed = '{
            mk(KIND_READ, REG_PRA, 8'h00, 0, 1, 8'h3f),
            mk(KIND_READ, REG_PRB, 8'h00, 0, 1, 8'hff),
            mk(KIND_READ, REG_TAHI, 8'h00, 0, 1, 8'hff),
            mk(KIND_READ, REG_ICR, 8'h00, 0, 1, 8'h00),
            mk(KIND_SPARE, REG_SDR, 8'hff, 1),
            mk(KIND_WRITE, REG_ICR, 8'h9f, 0),
            mk(KIND_WRITE, REG_TALO, 8'h02, 0),
            mk(KIND_WRITE, REG_TAHI, 8'h00, 0),
            mk(KIND_WRITE, REG_CRA, 8'h1f, 0),
            mk(KIND_TICK, REG_PRA, 8'h00, 0),
            mk(KIND_TICK, REG_PRA, 8'h00, 0),
            mk(KIND_TICK, REG_PRA, 8'h00, 0),
            mk(KIND_READ, REG_ICR, 8'h00, 0),
            mk(KIND_WRITE, REG_TBLO, 8'h01, 0),
            mk(KIND_WRITE, REG_TBHI, 8'h00, 0),
            mk(KIND_WRITE, REG_CRB, 8'h07, 0),
            mk(KIND_WRITE, REG_CRB, 8'hb0, 0),
            mk(KIND_WRITE, REG_TODH, 8'h12, 0),
            mk(KIND_WRITE, REG_CRB, 8'h2f, 0),
            mk(KIND_WRITE, REG_TODH, 8'h12, 0),
            mk(KIND_WRITE, REG_TODM, 8'h59, 0),
            mk(KIND_WRITE, REG_TODS, 8'h59, 0),
            mk(KIND_WRITE, REG_TOD10, 8'hff, 0),
            mk(KIND_TICK, REG_PRA, 8'h00, 1),
            mk(KIND_READ, REG_TODH, 8'h00, 0)
        };
        foreach (directed[i]) send(directed[i]);
        drain();

        for (ph = 0; ph < 6; ph++) begin
            set_cycles(cycle_set[ph]);
            stall_mode = ph % 3;
            if (ph == 2) hold_req = 1;
            burst = 0;
            for (i = 0; i < 155; i++) begin
                send(rnd_row());
                if (burst == 0) begin
                    burst = $urandom_range(1, 30);
                    gap = (ph == 4) ? 0 : $urandom_range(0, 4);
                    if (gap != 0) begin
                        s_tvalid <= 1'b0;
                        repeat (gap) @(posedge aclk);
                    end
                end else begin
                    burst--;
                end
            end
            drain();
        end

        $display("sent %0d items, checked %0d results, %0d timer underflows seen",
                 sent, received, underflows);
        $display("tick sizes 0, 1, 3, 9 and 65535 with random and long receiver stalls");
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
